// ===== sv/tts_pkg.sv =====
`default_nettype none

package tts_pkg;

   // Character codes used by the token match and the decimal formatting
   localparam logic [7:0] CH_A       = 8'h41;
   localparam logic [7:0] CH_D       = 8'h44;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SEVEN   = 8'h37;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;

   localparam logic [9:0] VALUE_MAX = 10'd999;

   // Window and output queue sizing
   localparam int WINDOW_DEPTH = 3;
   localparam int MAX_PUSH     = WINDOW_DEPTH + 1;
   localparam int QUEUE_DEPTH  = 8;
   localparam int PTR_W        = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int PUSH_W       = $clog2(MAX_PUSH + 1);

   typedef logic [WINDOW_DEPTH-1:0][7:0] digits_type;

   typedef struct packed {
      logic       last;
      logic [7:0] data;
   } entry_type;

   // Results of one request, slot 0 first
   typedef struct packed {
      logic [PUSH_W-1:0]           count;
      logic [MAX_PUSH-1:0][7:0]    data;
      logic [MAX_PUSH-1:0]         last;
   } push_type;

   typedef struct packed {
      logic               space_ok;
      logic [LEVEL_W-1:0] level;
   } status_type;

   // Saturate to 999 and write as space-padded three-digit decimal
   function automatic digits_type format_value(input logic [9:0] raw);
      logic [9:0] v;
      logic [3:0] h;
      logic [6:0] r;
      logic [3:0] t;
      logic [3:0] u;
      digits_type res;
      v = (raw > VALUE_MAX) ? VALUE_MAX : raw;
      h = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (v >= 10'(k * 100)) h = 4'(k);
      end
      r = 7'(v - 10'(h) * 10'd100);
      t = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (r >= 7'(k * 10)) t = 4'(k);
      end
      u = 4'(r - 7'(t) * 7'd10);
      res[0] = (v >= 10'd100) ? (CH_ZERO + {4'd0, h}) : CH_SPACE;
      res[1] = (v >= 10'd10)  ? (CH_ZERO + {4'd0, t}) : CH_SPACE;
      res[2] = CH_ZERO + {4'd0, u};
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== sv/tts_queue.sv =====
`default_nettype none

module tts_queue
   import tts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire push_type   push,
   input  wire logic       out_ready,
   output logic            out_valid,
   output logic [7:0]      out_byte,
   output logic            out_last,
   output status_type      status
);

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               pop;

   // Head of queue drives the response channel
   assign out_valid = (level_ff != '0);
   assign out_byte  = mem_ff[rd_ptr_ff].data;
   assign out_last  = mem_ff[rd_ptr_ff].last;
   assign pop       = out_valid & out_ready;

   assign status = '{space_ok: (level_ff <= LEVEL_W'(QUEUE_DEPTH - MAX_PUSH)),
                     level:    level_ff};

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      level_in  = level_ff + LEVEL_W'(push.count) - LEVEL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Store up to MAX_PUSH entries per cycle
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PUSH; i++) begin
         if (PUSH_W'(i) < push.count) begin
            mem_ff[wr_ptr_ff + PTR_W'(i)] <= '{last: push.last[i], data: push.data[i]};
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/template_token_substituter_top.sv =====
`default_nettype none

// Token substituter for an outgoing byte stream.
// Request channel (req_*): one segment byte per request, req_last_byte on the
// final byte, plus the channel and temperature values sampled with each byte.
// Response channel (rsp_*): segment bytes with "AD7%" and "ADA%" replaced by
// the value as space-padded three-digit decimal followed by the kept '%'.
// A three-byte window delays the stream: a byte leaves once three newer bytes
// are held, and the final request of a segment flushes the window, giving up
// to four responses with rsp_out_last on the last one.
// Each response is written into the output queue when its request is accepted.
// Throughput: one request per cycle while req_ready is high; the response
// side drains one byte per cycle while rsp_ready is high, so a segment end
// adds up to four bytes at once. An eight-entry output queue parts the two
// sides; req_ready drops while fewer than four entries are free, so a stalled
// receiver holds back requests before the queue overflows and no response is lost.
// Reset empties the window, zeroes its bytes and clears the output queue.
module template_token_substituter_top
   import tts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   input  wire logic [9:0] req_channel_value,
   input  wire logic [9:0] req_temperature_value,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last
);

   logic [7:0] win_ff [WINDOW_DEPTH];
   logic [7:0] win_in [WINDOW_DEPTH];
   logic [1:0] fill_ff, fill_in;
   logic [7:0] cur    [WINDOW_DEPTH];
   logic       accept;
   logic       is_full;
   logic       token_hit;
   digits_type chan_digits;
   digits_type temp_digits;
   push_type   push;
   status_type status;

   assign req_ready = status.space_ok;
   assign accept    = req_valid & req_ready;
   assign is_full   = (fill_ff == 2'(WINDOW_DEPTH));

   assign chan_digits = format_value(req_channel_value);
   assign temp_digits = format_value(req_temperature_value);

   // Match the token and overwrite the window with the formatted value
   always_comb begin
      token_hit = is_full && win_ff[0] == CH_A && win_ff[1] == CH_D
                  && req_data_byte == CH_PERCENT;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         cur[i] = win_ff[i];
         if (token_hit && win_ff[2] == CH_SEVEN) cur[i] = chan_digits[i];
         else if (token_hit && win_ff[2] == CH_A) cur[i] = temp_digits[i];
      end
   end

   // Build the results of this request and the next window
   always_comb begin
      for (int i = 0; i < MAX_PUSH; i++) begin
         push.data[i] = (i < WINDOW_DEPTH && 2'(i) < fill_ff) ? cur[i % WINDOW_DEPTH]
                                                              : req_data_byte;
         push.last[i] = req_last_byte && (2'(i) == fill_ff);
      end
      push.count = '0;
      fill_in    = fill_ff;
      for (int i = 0; i < WINDOW_DEPTH; i++) win_in[i] = win_ff[i];
      if (accept) begin
         if (req_last_byte) begin
            push.count = PUSH_W'(fill_ff) + PUSH_W'(1);
            fill_in    = 2'd0;
            for (int i = 0; i < WINDOW_DEPTH; i++) win_in[i] = 8'd0;
         end else if (is_full) begin
            push.count = PUSH_W'(1);
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) win_in[i] = cur[i + 1];
            win_in[WINDOW_DEPTH-1] = req_data_byte;
         end else begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
               if (2'(i) == fill_ff) win_in[i] = req_data_byte;
            end
            fill_in = fill_ff + 2'd1;
         end
      end
   end

   // Hold window and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
         for (int i = 0; i < WINDOW_DEPTH; i++) win_ff[i] <= 8'd0;
      end else begin
         fill_ff <= fill_in;
         for (int i = 0; i < WINDOW_DEPTH; i++) win_ff[i] <= win_in[i];
      end
   end

   tts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_byte  (rsp_out_byte),
      .out_last  (rsp_out_last),
      .status    (status)
   );

   // Queue never holds more than its depth
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.level <= LEVEL_W'(QUEUE_DEPTH))
      else $error("output queue overflow");

   // Final byte empties and zeroes the window
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> fill_ff == 2'd0 && win_ff[0] == 8'd0
      && win_ff[1] == 8'd0 && win_ff[2] == 8'd0)
      else $error("window not cleared after final byte");

   // Non-final byte into a partial window grows it by one
   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      accept && !req_last_byte && !is_full |=> fill_ff == $past(fill_ff) + 2'd1)
      else $error("window fill did not advance");

   // Nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

`default_nettype wire
